FILE: rtl/rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types, codes and reset constants of the leader election block.
// ----------------------------------------------------------------------------
package rle_pkg;

    // Command codes on the input channel
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_APP_REQ  = 3'd1;
    localparam logic [2:0] CMD_APP_RSP  = 3'd2;
    localparam logic [2:0] CMD_VOTE_REQ = 3'd3;
    localparam logic [2:0] CMD_VOTE_RSP = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_MY_ID    = 3'd0;
    localparam logic [2:0] CFG_NUM_SRV  = 3'd1;
    localparam logic [2:0] CFG_TO_MIN   = 3'd2;
    localparam logic [2:0] CFG_SPAN     = 3'd3;
    localparam logic [2:0] CFG_HB       = 3'd4;
    localparam logic [2:0] CFG_SEED     = 3'd5;

    // Configuration reset values
    localparam logic [7:0]  RST_MY_ID   = 8'd0;
    localparam logic [7:0]  RST_NUM_SRV = 8'd5;
    localparam logic [14:0] RST_TO_MIN  = 15'd5000;
    localparam logic [14:0] RST_SPAN    = 15'd4095;
    localparam logic [15:0] RST_HB      = 16'd1000;
    localparam logic [15:0] RST_SEED    = 16'd44257;
    localparam logic [15:0] RST_TIMEOUT = 16'(RST_TO_MIN) + (RST_SEED & 16'(RST_SPAN));

    // LFSR feedback taps
    localparam logic [15:0] LFSR_TAPS   = 16'hB400;

    typedef enum logic [2:0] {
        K_TICK,
        K_APP_REQ,
        K_APP_RSP,
        K_VOTE_REQ,
        K_VOTE_RSP,
        K_NONE
    } t_kind;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_VOTE_REQ     = 3'd1,
        ACT_HEARTBEAT    = 3'd2,
        ACT_APPEND_REPLY = 3'd3,
        ACT_VOTE_REPLY   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ROLE_FOLLOWER  = 2'd0,
        ROLE_CANDIDATE = 2'd1,
        ROLE_LEADER    = 2'd2
    } t_role;

    // Classified command travelling from front to back
    typedef struct packed {
        t_kind kind;
        logic  is_msg;
        logic  granted;
    } t_ctl;

    // One result item
    typedef struct packed {
        t_action     action;
        logic [31:0] term;
        logic        ok;
        t_role       role;
    } t_result;

    // One Galois step of the timeout LFSR
    function automatic logic [15:0] lfsr_step(input logic [15:0] cur);
        lfsr_step = {1'b0, cur[15:1]} ^ (cur[0] ? LFSR_TAPS : 16'h0000);
    endfunction

endpackage

FILE: rtl/rle_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_fifo
// Small synchronous queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module rle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/rle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_front
// Front end: classifies an incoming item and fits term and id to the core.
// ----------------------------------------------------------------------------
module rle_front
    import rle_pkg::*;
#(
    parameter int TERM_BITS = 32,
    parameter int ID_BITS   = 8
) (
    input  logic [2:0]           i_cmd,
    input  logic [31:0]          i_msg_term,
    input  logic [7:0]           i_candidate_id,
    input  logic                 i_vote_granted,
    output t_ctl                 o_ctl,
    output logic [TERM_BITS-1:0] o_term,
    output logic [ID_BITS-1:0]   o_cand
);
    logic [63:0] term_wide;
    logic [15:0] cand_wide;

    // fit the message fields to the internal widths
    assign term_wide = 64'(i_msg_term);
    assign cand_wide = 16'(i_candidate_id);
    assign o_term    = term_wide[TERM_BITS-1:0];
    assign o_cand    = cand_wide[ID_BITS-1:0];

    // command decode; unknown codes become a no-op
    always_comb begin
        o_ctl.granted = i_vote_granted;
        o_ctl.is_msg  = 1'b1;
        unique case (i_cmd)
            CMD_TICK: begin
                o_ctl.kind   = K_TICK;
                o_ctl.is_msg = 1'b0;
            end
            CMD_APP_REQ:  o_ctl.kind = K_APP_REQ;
            CMD_APP_RSP:  o_ctl.kind = K_APP_RSP;
            CMD_VOTE_REQ: o_ctl.kind = K_VOTE_REQ;
            CMD_VOTE_RSP: o_ctl.kind = K_VOTE_RSP;
            default: begin
                o_ctl.kind   = K_NONE;
                o_ctl.is_msg = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/rle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_core
// Back end: election state, timer, LFSR and configuration registers.
// ----------------------------------------------------------------------------
module rle_core
    import rle_pkg::*;
#(
    parameter int TERM_BITS = 32,
    parameter int ID_BITS   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_op_valid,
    input  t_ctl                 i_ctl,
    input  logic [TERM_BITS-1:0] i_term,
    input  logic [ID_BITS-1:0]   i_cand,
    input  logic                 i_res_full,
    output logic                 o_op_take,
    output t_result              o_result
);
    // configuration
    logic [7:0]  r_my_id;
    logic [7:0]  r_num_srv;
    logic [14:0] r_to_min;
    logic [14:0] r_span;
    logic [15:0] r_hb;

    // election state
    t_role                r_role,  n_role;
    logic [TERM_BITS-1:0] r_term,  n_term;
    logic                 r_vv,    n_vv;
    logic [ID_BITS-1:0]   r_vid,   n_vid;
    logic [7:0]           r_vc,    n_vc;
    logic [15:0]          r_to,    n_to;
    logic [15:0]          r_cd,    n_cd;
    logic [15:0]          r_lfsr,  n_lfsr;

    logic [15:0]          draw_lfsr;
    logic [15:0]          draw_to;
    logic [15:0]          id_wide;
    logic [ID_BITS-1:0]   self_id;
    logic [7:0]           half;
    logic [7:0]           vc_inc;
    logic                 higher;
    logic                 equal;
    t_action              act;
    logic                 ok;
    logic [63:0]          term_out;

    assign o_op_take = i_op_valid && !i_res_full;

    // next timeout draw and shared compares
    assign draw_lfsr = lfsr_step(r_lfsr);
    assign draw_to   = 16'(r_to_min) + (draw_lfsr & 16'(r_span));
    assign id_wide   = 16'(r_my_id);
    assign self_id   = id_wide[ID_BITS-1:0];
    assign half      = {1'b0, r_num_srv[7:1]};
    assign vc_inc    = (&r_vc) ? r_vc : r_vc + 8'd1;
    assign higher    = i_term > r_term;
    assign equal     = i_term == r_term;

    // one item's state update
    always_comb begin
        n_role = r_role;
        n_term = r_term;
        n_vv   = r_vv;
        n_vid  = r_vid;
        n_vc   = r_vc;
        n_to   = r_to;
        n_cd   = r_cd;
        n_lfsr = r_lfsr;
        act    = ACT_NONE;
        ok     = 1'b0;

        // any message with a newer term makes us a follower of that term
        if (i_ctl.is_msg && higher) begin
            n_term = i_term;
            n_vv   = 1'b0;
            n_vid  = '0;
            n_role = ROLE_FOLLOWER;
            n_lfsr = draw_lfsr;
            n_to   = draw_to;
            n_cd   = draw_to;
        end

        unique case (i_ctl.kind)
            K_TICK: begin
                if (r_cd > 16'd1) begin
                    n_cd = r_cd - 16'd1;
                end else if (r_role == ROLE_LEADER) begin
                    n_cd = r_to;
                    act  = ACT_HEARTBEAT;
                end else begin
                    // election start
                    n_role = ROLE_CANDIDATE;
                    if (~&r_term) begin
                        n_term = r_term + TERM_BITS'(1);
                    end
                    n_vv   = 1'b1;
                    n_vid  = self_id;
                    n_vc   = 8'd1;
                    n_lfsr = draw_lfsr;
                    n_to   = draw_to;
                    n_cd   = draw_to;
                    act    = ACT_VOTE_REQ;
                    // single-server cluster wins at once
                    if (8'd1 > half) begin
                        n_role = ROLE_LEADER;
                        n_to   = r_hb;
                        n_cd   = r_hb;
                        act    = ACT_HEARTBEAT;
                    end
                end
            end
            K_APP_REQ: begin
                if (!higher && equal && r_role == ROLE_CANDIDATE) begin
                    n_role = ROLE_FOLLOWER;
                    n_lfsr = draw_lfsr;
                    n_to   = draw_to;
                    n_cd   = draw_to;
                end
                act = ACT_APPEND_REPLY;
                if (higher || equal) begin
                    n_cd = n_to;
                    ok   = 1'b1;
                end
            end
            K_APP_RSP: begin
                act = ACT_NONE;
            end
            K_VOTE_REQ: begin
                act = ACT_VOTE_REPLY;
                if (higher || (equal && (!r_vv || r_vid == i_cand))) begin
                    n_vv  = 1'b1;
                    n_vid = i_cand;
                    n_cd  = n_to;
                    ok    = 1'b1;
                end
            end
            K_VOTE_RSP: begin
                if (!higher && equal && r_role == ROLE_CANDIDATE && i_ctl.granted) begin
                    n_vc = vc_inc;
                    if (vc_inc > half) begin
                        n_role = ROLE_LEADER;
                        n_to   = r_hb;
                        n_cd   = r_hb;
                        act    = ACT_HEARTBEAT;
                    end
                end
            end
            default: begin
                act = ACT_NONE;
            end
        endcase
    end

    // result item
    assign term_out        = 64'(n_term);
    assign o_result.action = act;
    assign o_result.term   = term_out[31:0];
    assign o_result.ok     = ok;
    assign o_result.role   = n_role;

    // configuration and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_id   <= RST_MY_ID;
            r_num_srv <= RST_NUM_SRV;
            r_to_min  <= RST_TO_MIN;
            r_span    <= RST_SPAN;
            r_hb      <= RST_HB;
            r_role    <= ROLE_FOLLOWER;
            r_term    <= '0;
            r_vv      <= 1'b0;
            r_vid     <= '0;
            r_vc      <= 8'd0;
            r_to      <= RST_TIMEOUT;
            r_cd      <= RST_TIMEOUT;
            r_lfsr    <= RST_SEED;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_MY_ID:   r_my_id   <= i_cfg_data[7:0];
                    CFG_NUM_SRV: r_num_srv <= i_cfg_data[7:0];
                    CFG_TO_MIN:  r_to_min  <= i_cfg_data[14:0];
                    CFG_SPAN:    r_span    <= i_cfg_data[14:0];
                    CFG_HB:      r_hb      <= i_cfg_data;
                    CFG_SEED:    ;  // only loads the LFSR, below
                    default:     ;
                endcase
            end
            if (o_op_take) begin
                r_role <= n_role;
                r_term <= n_term;
                r_vv   <= n_vv;
                r_vid  <= n_vid;
                r_vc   <= n_vc;
                r_to   <= n_to;
                r_cd   <= n_cd;
            end
            // a seed write reloads the LFSR; zero is forced to one
            if (i_cfg_wr_en && i_cfg_index == CFG_SEED) begin
                r_lfsr <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
            end else if (o_op_take) begin
                r_lfsr <= n_lfsr;
            end
        end
    end

endmodule

FILE: rtl/raft_leader_election_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raft_leader_election_top
// Raft leader election core: ticks and messages in, one action out per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive an item on i_cmd/i_msg_term/i_candidate_id/
//   i_vote_granted with push; it is taken on a clock edge where full is low.
//   Result channel: while empty is low the oldest result is on o_action,
//   o_out_term, o_out_ok and o_role; pop takes it.
//   Every item yields exactly one result item, in order.
//   An accepted item waits in the front queue; the core then writes its
//   result into the output queue, which drives the outputs.
//   Throughput: one item per cycle while the output queue is not full; the
//   core evaluates a whole item combinationally (term compares, timer and LFSR update side by side).
//   Stalls: while pop stays low the output queue fills to QUEUE_DEPTH
//   results, then the core waits on the oldest item in the front queue,
//   which takes up to QUEUE_DEPTH items before full rises.
//   Reset (i_rst_n low, synchronous) empties both queues, loads the
//   configuration defaults and starts as a follower at term zero.
//   Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index;
//   write only while no item is in flight.
// ----------------------------------------------------------------------------
module raft_leader_election_top
    import rle_pkg::*;
#(
    parameter int TERM_BITS   = 32,
    parameter int ID_BITS     = 8,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_msg_term,
    input  logic [7:0]  i_candidate_id,
    input  logic        i_vote_granted,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_action,
    output logic [31:0] o_out_term,
    output logic        o_out_ok,
    output logic [1:0]  o_role
);
    localparam int OP_W  = $bits(t_ctl) + TERM_BITS + ID_BITS;
    localparam int RES_W = $bits(t_result);

    t_ctl                 f_ctl;
    logic [TERM_BITS-1:0] f_term;
    logic [ID_BITS-1:0]   f_cand;
    logic [OP_W-1:0]      q_op;
    logic                 q_empty;
    t_ctl                 b_ctl;
    logic [TERM_BITS-1:0] b_term;
    logic [ID_BITS-1:0]   b_cand;
    logic                 b_take;
    t_result              b_result;
    logic                 res_full;
    logic [RES_W-1:0]     res_data;
    t_result              res;

    // front: classify
    rle_front #(
        .TERM_BITS (TERM_BITS),
        .ID_BITS   (ID_BITS)
    ) u_front (
        .i_cmd          (i_cmd),
        .i_msg_term     (i_msg_term),
        .i_candidate_id (i_candidate_id),
        .i_vote_granted (i_vote_granted),
        .o_ctl          (f_ctl),
        .o_term         (f_term),
        .o_cand         (f_cand)
    );

    // queue between front and core
    rle_fifo #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_term, f_cand}),
        .o_full  (full),
        .i_pop   (b_take),
        .o_data  (q_op),
        .o_empty (q_empty)
    );

    assign {b_ctl, b_term, b_cand} = q_op;

    // back: election core
    rle_core #(
        .TERM_BITS (TERM_BITS),
        .ID_BITS   (ID_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op_valid  (!q_empty),
        .i_ctl       (b_ctl),
        .i_term      (b_term),
        .i_cand      (b_cand),
        .i_res_full  (res_full),
        .o_op_take   (b_take),
        .o_result    (b_result)
    );

    // result queue
    rle_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_take),
        .i_data  (b_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_data),
        .o_empty (empty)
    );

    assign res        = res_data;
    assign o_action   = res.action;
    assign o_out_term = res.term;
    assign o_out_ok   = res.ok;
    assign o_role     = res.role;

    // a vote request broadcast only comes from a candidate
    a_votereq_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_action == ACT_VOTE_REQ) |-> o_role == ROLE_CANDIDATE)
        else $error("vote request result without candidate role");

    // a heartbeat only comes from a leader
    a_hb_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_action == ACT_HEARTBEAT) |-> o_role == ROLE_LEADER)
        else $error("heartbeat result without leader role");

    // the ok flag is only set on replies
    a_ok_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_ok) |->
            (o_action == ACT_APPEND_REPLY || o_action == ACT_VOTE_REPLY))
        else $error("ok flag on a non-reply result");

    // an item taken while no result waits shows up after the front and result queue registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && empty) |=> ##1 !empty)
        else $error("accepted item produced no result in time");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Raft leader election block. A directed script
// covers reset behavior, every command, the spare command codes, term
// adoption, elections, single-server wins and term saturation. Random phases
// under several register settings follow. Every answer the block pops out is
// compared with a hand-written value or a cycle-free model of the election logic kept in this file.
// ----------------------------------------------------------------------------
module testbench;
    import rle_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 4;       // quiet time before a register write
    localparam int HOLD_CYCLES  = 200;     // long receiver hold-off
    localparam int MSGS_PER_PHASE = 70;
    // Watchdog limit, with a wide margin over the slowest run
    localparam int CYCLE_LIMIT  = 200000;

    // Command codes the block ignores
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // Block ports
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_wr_en    = 1'b0;
    logic [2:0]  i_cfg_index    = '0;
    logic [15:0] i_cfg_data     = '0;
    logic        push           = 1'b0;
    logic        full;
    logic [2:0]  i_cmd          = '0;
    logic [31:0] i_msg_term     = '0;
    logic [7:0]  i_candidate_id = '0;
    logic        i_vote_granted = 1'b0;
    logic        empty;
    logic        pop            = 1'b0;
    logic [2:0]  o_action;
    logic [31:0] o_out_term;
    logic        o_out_ok;
    logic [1:0]  o_role;

    raft_leader_election_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_msg_term     (i_msg_term),
        .i_candidate_id (i_candidate_id),
        .i_vote_granted (i_vote_granted),
        .empty          (empty),
        .pop            (pop),
        .o_action       (o_action),
        .o_out_term     (o_out_term),
        .o_out_ok       (o_out_ok),
        .o_role         (o_role)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Register copies
    logic [7:0]  reg_my_id;
    logic [7:0]  reg_nsrv;
    logic [14:0] reg_to_min;
    logic [14:0] reg_span;
    logic [15:0] reg_hb;
    logic [15:0] reg_seed;

    // Server state as the block should hold it
    t_role       st_role;
    logic [31:0] st_term;
    logic        st_voted;
    logic [7:0]  st_vote_for;
    logic [7:0]  st_votes;
    logic [15:0] st_timeout;
    logic [15:0] st_countdown;
    logic [15:0] st_lfsr;

    // Answers owed by the block, oldest first
    t_result answers_due[$];
    t_result head_answer;
    t_result got_answer;

    // Run control and statistics
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit pressure_go   = 1'b0;
    logic rx_hold     = 1'b0;
    int cycle_count   = 0;
    int mismatch_count = 0;
    int answers_seen  = 0;
    int items_sent    = 0;
    int elections     = 0;
    int takeovers     = 0;
    int full_stalls   = 0;

    // Directed script
    typedef struct {
        bit          is_cfg;
        logic [2:0]  cfg_index;
        logic [15:0] cfg_value;
        logic [2:0]  cmd;
        logic [31:0] term;
        logic [7:0]  cand;
        logic        granted;
        bit          typed;
        t_result     want;
    } t_script_row;

    t_script_row script[$];
    int          opening_rows;

    // ------------------------------------------------------------------
    // Election model
    // ------------------------------------------------------------------

    // Advance the Galois LFSR and pick a fresh election timeout
    function automatic void draw_new_timeout();
        if (st_lfsr[0]) begin
            st_lfsr = (st_lfsr >> 1) ^ LFSR_TAPS;
        end else begin
            st_lfsr = st_lfsr >> 1;
        end
        st_timeout = 16'(reg_to_min) + (st_lfsr & 16'(reg_span));
    endfunction

    function automatic void step_down();
        st_role = ROLE_FOLLOWER;
        draw_new_timeout();
        st_countdown = st_timeout;
    endfunction

    function automatic void take_lead();
        st_role      = ROLE_LEADER;
        st_timeout   = reg_hb;
        st_countdown = st_timeout;
        takeovers++;
    endfunction

    function automatic void adopt_term(input logic [31:0] term);
        st_term     = term;
        st_voted    = 1'b0;
        st_vote_for = '0;
        step_down();
    endfunction

    // One item in, the answer the block owes for it
    function automatic t_result raft_answer(input logic [2:0] cmd, input logic [31:0] term,
                                            input logic [7:0] cand, input logic granted);
        t_result r;
        r.action = ACT_NONE;
        r.ok     = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (st_countdown > 16'd1) begin
                    st_countdown = st_countdown - 16'd1;
                end else if (st_role == ROLE_LEADER) begin
                    st_countdown = st_timeout;
                    r.action     = ACT_HEARTBEAT;
                end else begin
                    // timer expired: stand for election, term holds at its top
                    st_role = ROLE_CANDIDATE;
                    if (st_term != '1) st_term = st_term + 32'd1;
                    st_voted    = 1'b1;
                    st_vote_for = reg_my_id;
                    st_votes    = 8'd1;
                    draw_new_timeout();
                    st_countdown = st_timeout;
                    elections++;
                    if (st_votes > reg_nsrv / 2) begin
                        take_lead();
                        r.action = ACT_HEARTBEAT;
                    end else begin
                        r.action = ACT_VOTE_REQ;
                    end
                end
            end
            CMD_APP_REQ: begin
                if (term > st_term) adopt_term(term);
                if (st_role == ROLE_CANDIDATE && term == st_term) step_down();
                r.action = ACT_APPEND_REPLY;
                if (term >= st_term) begin
                    st_countdown = st_timeout;
                    r.ok         = 1'b1;
                end
            end
            CMD_APP_RSP: begin
                if (term > st_term) adopt_term(term);
            end
            CMD_VOTE_REQ: begin
                // a newer term still lets the request be granted
                if (term > st_term) adopt_term(term);
                r.action = ACT_VOTE_REPLY;
                if (term >= st_term && (!st_voted || st_vote_for == cand)) begin
                    st_voted     = 1'b1;
                    st_vote_for  = cand;
                    st_countdown = st_timeout;
                    r.ok         = 1'b1;
                end
            end
            CMD_VOTE_RSP: begin
                if (term > st_term) begin
                    adopt_term(term);
                end else if (term == st_term && st_role == ROLE_CANDIDATE && granted) begin
                    if (st_votes != 8'hFF) st_votes = st_votes + 8'd1;
                    if (st_votes > reg_nsrv / 2) begin
                        take_lead();
                        r.action = ACT_HEARTBEAT;
                    end
                end
            end
            default: ;
        endcase
        r.term = st_term;
        r.role = st_role;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one item, wait for the handshake, then book its answer
    task automatic send_msg(input logic [2:0] cmd, input logic [31:0] term,
                            input logic [7:0] cand, input logic granted,
                            input bit typed, input t_result want);
        t_result model_answer;
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_cmd          <= cmd;
        i_msg_term     <= term;
        i_candidate_id <= cand;
        i_vote_granted <= granted;
        do @(posedge i_clk); while (full);
        model_answer = raft_answer(cmd, term, cand, granted);
        answers_due.push_back(typed ? want : model_answer);
        items_sent++;
    endtask

    // Register write once the block has gone quiet
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        push <= 1'b0;
        @(posedge i_clk);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MY_ID:   reg_my_id  = data[7:0];
            CFG_NUM_SRV: reg_nsrv   = data[7:0];
            CFG_TO_MIN:  reg_to_min = data[14:0];
            CFG_SPAN:    reg_span   = data[14:0];
            CFG_HB:      reg_hb     = data;
            CFG_SEED: begin
                // a zero seed loads one so the LFSR cannot lock up
                reg_seed = data;
                st_lfsr  = (data == 16'd0) ? 16'd1 : data;
            end
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] my_id, input logic [15:0] nsrv,
                            input logic [15:0] to_min, input logic [15:0] span,
                            input logic [15:0] hb, input logic [15:0] seed);
        write_reg(CFG_MY_ID, my_id);
        write_reg(CFG_NUM_SRV, nsrv);
        write_reg(CFG_TO_MIN, to_min);
        write_reg(CFG_SPAN, span);
        write_reg(CFG_HB, hb);
        write_reg(CFG_SEED, seed);
    endtask

    function automatic void note_cfg(input logic [2:0] idx, input logic [15:0] value);
        t_script_row row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.cfg_index = idx;
        row.cfg_value = value;
        script.push_back(row);
    endfunction

    function automatic void note_msg(input logic [2:0] cmd, input logic [31:0] term,
                                     input logic [7:0] cand, input logic granted);
        t_script_row row;
        row         = '{default: '0};
        row.cmd     = cmd;
        row.term    = term;
        row.cand    = cand;
        row.granted = granted;
        script.push_back(row);
    endfunction

    // Row whose answer is written out by hand
    function automatic void note_typed(input logic [2:0] cmd, input logic [31:0] term,
                                       input logic [7:0] cand, input logic granted,
                                       input t_action act, input logic [31:0] out_term,
                                       input logic ok, input t_role role);
        t_script_row row;
        row             = '{default: '0};
        row.cmd         = cmd;
        row.term        = term;
        row.cand        = cand;
        row.granted     = granted;
        row.typed       = 1'b1;
        row.want.action = act;
        row.want.term   = out_term;
        row.want.ok     = ok;
        row.want.role   = role;
        script.push_back(row);
    endfunction

    task automatic run_script(input int first, input int last);
        t_script_row row;
        for (int n = first; n < last; n++) begin
            row = script[n];
            if (row.is_cfg) begin
                write_reg(row.cfg_index, row.cfg_value);
            end else begin
                send_msg(row.cmd, row.term, row.cand, row.granted, row.typed, row.want);
            end
        end
    endtask

    // Mostly terms near the current one, now and then a jump
    function automatic logic [31:0] pick_term();
        int r;
        r = $urandom_range(39);
        if (r < 20) return st_term;
        if (r < 28) return (st_term == '1) ? st_term : st_term + 32'd1;
        if (r < 34) return (st_term == '0) ? st_term : st_term - 32'd1;
        if (r < 38) return $urandom_range(15);
        if (r == 38) return $urandom;
        return st_term + $urandom_range(1, 100);
    endfunction

    // Random traffic shaped like a cluster: ticks, votes and appends
    task automatic run_phase(input int n_msgs);
        int          done;
        int          pick;
        logic [2:0]  cmd;
        logic [31:0] term;
        logic [7:0]  cand;
        logic        granted;
        t_result     no_answer;
        done      = 0;
        no_answer = '0;
        while (done < n_msgs) begin
            pick    = $urandom_range(99);
            term    = pick_term();
            cand    = 8'($urandom);
            granted = ($urandom_range(3) != 0);
            if (pick < 35) begin
                cmd = CMD_TICK;
            end else if (pick < 52) begin
                cmd = CMD_VOTE_RSP;
            end else if (pick < 66) begin
                cmd = CMD_APP_REQ;
            end else if (pick < 80) begin
                cmd = CMD_VOTE_REQ;
                case ($urandom_range(2))
                    0: cand = reg_my_id;
                    1: cand = st_vote_for;
                    default: ;
                endcase
            end else if (pick < 90) begin
                cmd = CMD_APP_RSP;
            end else if (pick < 95) begin
                cmd  = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
                term = $urandom;
            end else begin
                // noise: any code, any term
                cmd  = 3'($urandom);
                term = $urandom;
            end
            send_msg(cmd, term, cand, granted, 1'b0, no_answer);
            if (cmd <= CMD_VOTE_RSP) done++;
        end
    endtask

    // ------------------------------------------------------------------
    // Answer checking and receiver stalls
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input t_result got, input t_result want);
        mismatch_count++;
        $display({"MISMATCH at %0t, answer %0d (%s): got act %0d term %0h ok %0d role %0d,",
                  " want act %0d term %0h ok %0d role %0d"},
                 $time, answers_seen, what, got.action, got.term, got.ok, got.role,
                 want.action, want.term, want.ok, want.role);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (push && full) full_stalls++;
            if (pop && !empty) begin
                got_answer.action = t_action'(o_action);
                got_answer.term   = o_out_term;
                got_answer.ok     = o_out_ok;
                got_answer.role   = t_role'(o_role);
                if (answers_due.size() == 0) begin
                    flag_mismatch("nothing outstanding", got_answer, '0);
                end else begin
                    head_answer = answers_due.pop_front();
                    if (got_answer.action !== head_answer.action ||
                        got_answer.term   !== head_answer.term ||
                        got_answer.ok     !== head_answer.ok ||
                        got_answer.role   !== head_answer.role) begin
                        flag_mismatch("field differs", got_answer, head_answer);
                    end
                end
                answers_seen++;
            end
            pop <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off so the queues fill and full rises
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, answers_due.size());
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Reset defaults, answers read straight off the rules
        note_typed(CMD_TICK, 32'd0, 8'h00, 1'b0, ACT_NONE, 32'd0, 1'b0, ROLE_FOLLOWER);
        note_typed(CMD_APP_REQ, 32'd0, 8'h00, 1'b0, ACT_APPEND_REPLY, 32'd0, 1'b1,
                   ROLE_FOLLOWER);
        note_typed(CMD_VOTE_REQ, 32'd0, 8'hFF, 1'b0, ACT_VOTE_REPLY, 32'd0, 1'b1,
                   ROLE_FOLLOWER);
        note_typed(CMD_VOTE_REQ, 32'd0, 8'h00, 1'b1, ACT_VOTE_REPLY, 32'd0, 1'b0,
                   ROLE_FOLLOWER);
        note_typed(CMD_VOTE_RSP, 32'd0, 8'h00, 1'b1, ACT_NONE, 32'd0, 1'b0, ROLE_FOLLOWER);
        // spare codes are ignored even with a maximal term
        note_typed(CMD_SPARE_5, 32'hFFFF_FFFF, 8'hFF, 1'b1, ACT_NONE, 32'd0, 1'b0,
                   ROLE_FOLLOWER);
        note_typed(CMD_SPARE_6, 32'hFFFF_FFFF, 8'hFF, 1'b1, ACT_NONE, 32'd0, 1'b0,
                   ROLE_FOLLOWER);
        note_typed(CMD_SPARE_7, 32'hFFFF_FFFF, 8'hFF, 1'b1, ACT_NONE, 32'd0, 1'b0,
                   ROLE_FOLLOWER);
        note_typed(CMD_APP_RSP, 32'd7, 8'h00, 1'b0, ACT_NONE, 32'd7, 1'b0, ROLE_FOLLOWER);
        // stale append is refused
        note_typed(CMD_APP_REQ, 32'd3, 8'h00, 1'b0, ACT_APPEND_REPLY, 32'd7, 1'b0,
                   ROLE_FOLLOWER);
        // newer term, vote still granted
        note_typed(CMD_VOTE_REQ, 32'd9, 8'd4, 1'b0, ACT_VOTE_REPLY, 32'd9, 1'b1,
                   ROLE_FOLLOWER);
        note_typed(CMD_VOTE_REQ, 32'd9, 8'd5, 1'b0, ACT_VOTE_REPLY, 32'd9, 1'b0,
                   ROLE_FOLLOWER);
        // Fast timers, three servers, zero seed
        note_cfg(CFG_MY_ID, 16'd3);
        note_cfg(CFG_NUM_SRV, 16'd3);
        note_cfg(CFG_TO_MIN, 16'd1);
        note_cfg(CFG_SPAN, 16'd0);
        note_cfg(CFG_HB, 16'd1);
        note_cfg(CFG_SEED, 16'd0);
        note_msg(CMD_APP_REQ, 32'd10, 8'h00, 1'b0);
        note_msg(CMD_TICK, 32'd0, 8'h00, 1'b0);          // election
        note_msg(CMD_VOTE_RSP, 32'd11, 8'h00, 1'b0);     // refused vote
        note_msg(CMD_VOTE_RSP, 32'd11, 8'h00, 1'b1);     // majority
        note_msg(CMD_TICK, 32'd0, 8'h00, 1'b0);          // heartbeat
        note_msg(CMD_VOTE_REQ, 32'd11, 8'd3, 1'b0);
        note_msg(CMD_APP_REQ, 32'd11, 8'h00, 1'b0);
        note_msg(CMD_APP_RSP, 32'd12, 8'h00, 1'b0);      // leader steps down
        note_msg(CMD_TICK, 32'd0, 8'h00, 1'b0);
        note_msg(CMD_APP_REQ, 32'd13, 8'h00, 1'b0);      // candidate yields
        // Single server wins on its own vote
        note_cfg(CFG_NUM_SRV, 16'd1);
        note_msg(CMD_TICK, 32'd0, 8'h00, 1'b0);
        note_msg(CMD_VOTE_RSP, 32'd20, 8'h00, 1'b1);
        note_typed(CMD_VOTE_REQ, 32'd0, 8'h00, 1'b0, ACT_VOTE_REPLY, 32'd20, 1'b0,
                   ROLE_FOLLOWER);
        opening_rows = script.size();
        // Closing rows: election at the top term keeps the term
        note_cfg(CFG_NUM_SRV, 16'd2);
        note_cfg(CFG_TO_MIN, 16'd1);
        note_cfg(CFG_SPAN, 16'd0);
        note_typed(CMD_APP_RSP, 32'hFFFF_FFFF, 8'h00, 1'b0, ACT_NONE, 32'hFFFF_FFFF, 1'b0,
                   ROLE_FOLLOWER);
        note_msg(CMD_TICK, 32'd0, 8'h00, 1'b0);
        note_msg(CMD_VOTE_RSP, 32'hFFFF_FFFF, 8'h00, 1'b1);
        note_msg(CMD_TICK, 32'd0, 8'h00, 1'b0);
        note_msg(CMD_APP_REQ, 32'hFFFF_FFFF, 8'h00, 1'b0);

        // Reset, then mirror the default state
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reg_my_id    = RST_MY_ID;
        reg_nsrv     = RST_NUM_SRV;
        reg_to_min   = RST_TO_MIN;
        reg_span     = RST_SPAN;
        reg_hb       = RST_HB;
        reg_seed     = RST_SEED;
        st_role      = ROLE_FOLLOWER;
        st_term      = '0;
        st_voted     = 1'b0;
        st_vote_for  = '0;
        st_votes     = '0;
        st_lfsr      = reg_seed;
        st_timeout   = 16'(reg_to_min) + (reg_seed & 16'(reg_span));
        st_countdown = st_timeout;

        // Sender idles lightly, receiver heavily
        send_idle_pct = 20;
        recv_idle_pct = 45;
        run_script(0, opening_rows);
        set_regs(16'($urandom_range(255)), 16'd5, 16'd1, 16'd3, 16'd1, 16'd0);
        run_phase(MSGS_PER_PHASE);
        set_regs(16'd255, 16'd255, 16'd2, 16'd7, 16'd3, 16'hFFFF);
        run_phase(MSGS_PER_PHASE);

        // Roles swapped
        send_idle_pct = 45;
        recv_idle_pct = 20;
        set_regs(16'($urandom_range(255)), 16'($urandom_range(1, 9)),
                 16'($urandom_range(1, 8)), 16'($urandom_range(0, 15)),
                 16'($urandom_range(1, 6)), 16'($urandom_range(1, 65535)));
        run_phase(MSGS_PER_PHASE);
        set_regs(16'($urandom_range(255)), 16'($urandom_range(1, 9)), 16'd32767, 16'd32767,
                 16'hFFFF, 16'($urandom_range(1, 65535)));
        run_phase(MSGS_PER_PHASE);

        // No idling, with one long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(16'($urandom_range(255)), 16'($urandom_range(1, 9)),
                 16'($urandom_range(1, 8)), 16'($urandom_range(0, 15)),
                 16'($urandom_range(1, 6)), 16'($urandom_range(1, 65535)));
        pressure_go = 1'b1;
        run_phase(MSGS_PER_PHASE);
        run_script(opening_rows, script.size());

        // Drain
        push <= 1'b0;
        @(posedge i_clk);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);

        $display("Run covered %0d items and %0d answers over five register settings",
                 items_sent, answers_seen);
        $display("Elections started %0d, leaderships taken %0d, cycles stalled on full %0d",
                 elections, takeovers, full_stalls);
        if (mismatch_count == 0 && answers_due.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
